// File: rtl/uad_pkg.sv
// ----------------------------------------------------------------------------
// Upwind artificial diffusion - shared definitions
// Field widths, action codes, diagonal word layout and the arithmetic helpers.
// ----------------------------------------------------------------------------
package uad_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACC_W = 40;
  localparam int unsigned D_W   = 32;

  typedef enum logic {
    ACT_PROCESS = 1'b0,
    ACT_READ    = 1'b1
  } action_e;

  // One diagonal entry: accumulator and sticky saturation mark
  typedef struct packed {
    logic                    mark;
    logic signed [ACC_W-1:0] sum;
  } diag_word_t;

  localparam diag_word_t DIAG_ZERO = '0;
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Item held between the memory read and the write-back
  typedef struct packed {
    action_e          action;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic             i_ok;
    logic             upd;
    logic [D_W-1:0]   d;
    logic             fwd_i;
    logic             fwd_j;
    diag_word_t       fwd_i_word;
    diag_word_t       fwd_j_word;
  } stage_t;

  // d = max(0, -a_ij, -a_ji), exact in 33 bits; result fits 0..2^31 unsigned
  function automatic logic [D_W-1:0] diffusion(logic signed [VAL_W-1:0] upper,
                                               logic signed [VAL_W-1:0] lower);
    logic signed [VAL_W:0] neg_u;
    logic signed [VAL_W:0] neg_l;
    logic signed [VAL_W:0] best;
    neg_u = (VAL_W+1)'(0) - $signed({upper[VAL_W-1], upper});
    neg_l = (VAL_W+1)'(0) - $signed({lower[VAL_W-1], lower});
    best  = (neg_u >= neg_l) ? neg_u : neg_l;
    return (best > 0) ? best[D_W-1:0] : '0;
  endfunction

  // sum - d, clamped at the negative limit; clamp sets the mark
  function automatic diag_word_t sub_sat(diag_word_t w, logic [D_W-1:0] d);
    logic [ACC_W:0] diff;
    diag_word_t     r;
    diff   = {w.sum[ACC_W-1], w.sum} - {{(ACC_W+1-D_W){1'b0}}, d};
    r.mark = w.mark;
    r.sum  = diff[ACC_W-1:0];
    if (diff[ACC_W] != diff[ACC_W-1]) begin
      r.mark = 1'b1;
      r.sum  = ACC_MIN;
    end
    return r;
  endfunction

endpackage

// File: rtl/uad_diag_ram.sv
// ----------------------------------------------------------------------------
// Diagonal accumulator memory
// Two read ports with registered data and two write ports; a read sees the
// contents before a write to the same entry in the same cycle.
// ----------------------------------------------------------------------------
module uad_diag_ram
  import uad_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_a_addr_i,
  input  logic [AW-1:0] rd_b_addr_i,
  output diag_word_t    rd_a_data_o,
  output diag_word_t    rd_b_data_o,
  input  logic          wr_a_en_i,
  input  logic [AW-1:0] wr_a_addr_i,
  input  diag_word_t    wr_a_data_i,
  input  logic          wr_b_en_i,
  input  logic [AW-1:0] wr_b_addr_i,
  input  diag_word_t    wr_b_data_i
);

  diag_word_t mem [DEPTH];
  diag_word_t rd_a_q;
  diag_word_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem[rd_a_addr_i];
      rd_b_q <= mem[rd_b_addr_i];
    end
    if (wr_a_en_i) begin
      mem[wr_a_addr_i] <= wr_a_data_i;
    end
    if (wr_b_en_i) begin
      mem[wr_b_addr_i] <= wr_b_data_i;
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

// File: rtl/upwind_artificial_diffusion_top.sv
// ----------------------------------------------------------------------------
// Upwind artificial diffusion
// Discrete-upwinding diffusion entries and diagonal accumulators for FCT.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle unless the output stalls, and
// answers each with one result transfer (memory read, then read-modify-write
// into the output register), for process and read actions alike. The
// diagonal accumulators live in one memory with two read and two write
// ports; a new item reads both nodes while the item before it writes back,
// and the pending write values are forwarded to it. After reset the block
// runs a clearing pass over min(NODES, 1024) entries, one entry per cycle,
// with s_axis_tready low; results stall only when m_axis_tready is held low.
module upwind_artificial_diffusion_top
  import uad_pkg::*;
#(
  parameter int unsigned NODES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_index[9:0], second_index[19:10], upper_value[51:20],
  // lower_value[83:52], first_active[84], second_active[85], zero pad
  input  logic [87:0] s_axis_tdata,
  // action[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_index[9:0], result_value[49:10], zero pad
  output logic [55:0] m_axis_tdata,
  // saturated[0]
  output logic [0:0]  m_axis_tuser
);

  localparam int unsigned DEPTH = (NODES < (1 << IDX_W)) ? NODES : (1 << IDX_W);
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e  state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // Input fields
  action_e                 in_action;
  logic [IDX_W-1:0]        in_first;
  logic [IDX_W-1:0]        in_second;
  logic signed [VAL_W-1:0] in_upper;
  logic signed [VAL_W-1:0] in_lower;
  logic                    in_first_act;
  logic                    in_second_act;

  assign in_action     = action_e'(s_axis_tuser[0]);
  assign in_first      = s_axis_tdata[9:0];
  assign in_second     = s_axis_tdata[19:10];
  assign in_upper      = s_axis_tdata[51:20];
  assign in_lower      = s_axis_tdata[83:52];
  assign in_first_act  = s_axis_tdata[84];
  assign in_second_act = s_axis_tdata[85];

  stage_t        s1_q, s1_d;
  logic          s1_v_q, s1_v_d;
  logic          s1_fire;
  logic          accept;

  logic          out_v_q, out_v_d;
  logic [IDX_W-1:0] out_idx_q;
  logic [ACC_W-1:0] out_val_q;
  logic          out_sat_q;

  // Memory ports
  diag_word_t    rd_a_data, rd_b_data;
  logic          wr_a_en, wr_b_en;
  logic [AW-1:0] wr_a_addr, wr_b_addr;
  diag_word_t    wr_a_data, wr_b_data;

  // Decode of the incoming item
  logic          i_ok, j_ok, pair_ok;
  logic [D_W-1:0] d_raw;
  logic          hit_ia, hit_ib, hit_ja, hit_jb;

  // Read-modify-write stage
  diag_word_t    cur_i, cur_j, new_i, new_j;
  logic          s1_read;
  logic [ACC_W-1:0] res_val;
  logic          res_sat;

  assign s1_fire       = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_RUN) && (!s1_v_q || s1_fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign i_ok    = 32'(in_first) < NODES;
  assign j_ok    = 32'(in_second) < NODES;
  assign pair_ok = (in_first != in_second) && in_first_act && in_second_act && i_ok && j_ok;
  assign d_raw   = diffusion(in_upper, in_lower);

  // Compare against the write-back happening in this same cycle
  assign hit_ia = wr_a_en && (in_first[AW-1:0] == wr_a_addr);
  assign hit_ib = wr_b_en && (in_first[AW-1:0] == wr_b_addr);
  assign hit_ja = wr_a_en && (in_second[AW-1:0] == wr_a_addr);
  assign hit_jb = wr_b_en && (in_second[AW-1:0] == wr_b_addr);

  always_comb begin
    s1_d            = s1_q;
    s1_d.action     = in_action;
    s1_d.idx_i      = in_first;
    s1_d.idx_j      = in_second;
    s1_d.i_ok       = i_ok;
    s1_d.d          = pair_ok ? d_raw : '0;
    s1_d.upd        = (in_action == ACT_PROCESS) && pair_ok && (d_raw != '0);
    s1_d.fwd_i      = hit_ia || hit_ib;
    s1_d.fwd_j      = hit_ja || hit_jb;
    s1_d.fwd_i_word = hit_ia ? wr_a_data : wr_b_data;
    s1_d.fwd_j_word = hit_ja ? wr_a_data : wr_b_data;
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = 1'b1;
    end else if (s1_fire) begin
      s1_v_d = 1'b0;
    end
  end

  assign cur_i   = s1_q.fwd_i ? s1_q.fwd_i_word : rd_a_data;
  assign cur_j   = s1_q.fwd_j ? s1_q.fwd_j_word : rd_b_data;
  assign new_i   = sub_sat(cur_i, s1_q.d);
  assign new_j   = sub_sat(cur_j, s1_q.d);
  assign s1_read = (s1_q.action == ACT_READ);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_a_en   = 1'b1;
      wr_a_addr = clr_cnt_q;
      wr_a_data = DIAG_ZERO;
    end else begin
      wr_a_en   = s1_fire && (s1_read ? s1_q.i_ok : s1_q.upd);
      wr_a_addr = s1_q.idx_i[AW-1:0];
      wr_a_data = s1_read ? DIAG_ZERO : new_i;
    end
    wr_b_en   = s1_fire && !s1_read && s1_q.upd;
    wr_b_addr = s1_q.idx_j[AW-1:0];
    wr_b_data = new_j;
  end

  always_comb begin
    if (s1_read) begin
      res_val = s1_q.i_ok ? cur_i.sum : '0;
      res_sat = s1_q.i_ok && cur_i.mark;
    end else begin
      res_val = ACC_W'(s1_q.d);
      res_sat = s1_q.upd && (new_i.mark || new_j.mark);
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (s1_fire) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  // Clearing pass after reset
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  uad_diag_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_diag_ram (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_a_addr_i (in_first[AW-1:0]),
    .rd_b_addr_i (in_second[AW-1:0]),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data),
    .wr_a_en_i   (wr_a_en),
    .wr_a_addr_i (wr_a_addr),
    .wr_a_data_i (wr_a_data),
    .wr_b_en_i   (wr_b_en),
    .wr_b_addr_i (wr_b_addr),
    .wr_b_data_i (wr_b_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      s1_v_q    <= s1_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_fire) begin
      out_idx_q <= s1_q.idx_i;
      out_val_q <= res_val;
      out_sat_q <= res_sat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_val_q, out_idx_q};
  assign m_axis_tuser  = out_sat_q;

endmodule
